### sv/btm_pkg.sv
// Shared types and constants for the 3x3 box threshold marker.
package btm_pkg;

	localparam int PIX_W      = 5;
	localparam int POS_W      = 5;
	localparam int SUM_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [PIX_W-1:0] PIXEL_MAX = 5'd20;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLUMNS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STAR_SUM_THRESHOLD = 2'd2;

	localparam logic [5:0] FRAME_COLUMNS_RST      = 6'd20;
	localparam logic [5:0] FRAME_ROWS_RST         = 6'd20;
	localparam logic [7:0] STAR_SUM_THRESHOLD_RST = 8'd54;

	typedef enum logic [1:0] {
		MARK_BLANK = 2'd0,
		MARK_DOT   = 2'd1,
		MARK_STAR  = 2'd2
	} mark_t;

	// Position and flags of the pixel that a beat classifies.
	typedef struct packed {
		logic             emit;
		logic             blank;
		logic             done;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} tag_t;

endpackage

### sv/box3x3_threshold_marker.sv
// Pixels enter in raster order, one beat per clock, and each pixel at (r, c) with r and c
// both nonzero yields one result beat that classifies pixel (r-1, c-1) as blank border,
// dot, or star (3x3 sum above star_sum_threshold). The two line-buffer RAMs are read at the
// accepting edge together with the stage-1 register, and the window sum is loaded into the
// result register at the edge where stage 1 advances. Sustained rate is one pixel per clock;
// the input stalls only while a finished result waits on result_ready and the pipeline stage
// behind it also holds a result. Writes to the three configuration registers take effect at
// once and restart the frame.
module box3x3_threshold_marker #(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [btm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [btm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pixel_valid,
	output logic                            pixel_ready,
	input  logic [4:0]                      pixel_value,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [4:0]                      center_row,
	output logic [4:0]                      center_col,
	output logic [1:0]                      mark,
	output logic                            frame_done
);

	localparam int CW = $clog2(MAX_COLS);

	logic                       accept;
	logic [btm_pkg::PIX_W-1:0]  pix_sat;
	logic [CW-1:0]              col_idx;
	btm_pkg::tag_t              tag;
	logic [7:0]                 threshold;
	logic [btm_pkg::PIX_W-1:0]  up_rd;
	logic [btm_pkg::PIX_W-1:0]  mid_rd;
	btm_pkg::mark_t             mark_c;

	logic                       v_s1;
	logic [btm_pkg::PIX_W-1:0]  pix_s1;
	logic [CW-1:0]              col_s1;
	btm_pkg::tag_t              tag_s1;
	logic                       adv;
	logic                       done_s1;

	logic                       result_valid_q;
	logic [4:0]                 row_q;
	logic [4:0]                 col_q;
	btm_pkg::mark_t             mark_q;
	logic                       frame_done_q;

	assign cfg_ready = 1'b1;

	// Stage 1 only blocks when it holds a result and the result register cannot take it.
	assign adv         = !(v_s1 && tag_s1.emit) || !result_valid_q || result_ready;
	assign pixel_ready = adv;
	assign accept      = pixel_valid && pixel_ready;
	assign done_s1     = v_s1 && adv;

	assign pix_sat = (pixel_value > btm_pkg::PIXEL_MAX) ? btm_pkg::PIXEL_MAX : pixel_value;

	btm_ctrl #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.advance(accept),
		.col_idx(col_idx),
		.tag(tag),
		.threshold(threshold)
	);

	// Middle row buffer is written with the new pixel as it is read.
	btm_ram #(
		.WIDTH(btm_pkg::PIX_W),
		.DEPTH(MAX_COLS)
	) u_mid_ram (
		.clk(clk),
		.wr_en(accept),
		.wr_addr(col_idx),
		.wr_data(pix_sat),
		.rd_en(accept),
		.rd_addr(col_idx),
		.rd_data(mid_rd)
	);

	// Upper row buffer takes the old middle value once it has been read out.
	btm_ram #(
		.WIDTH(btm_pkg::PIX_W),
		.DEPTH(MAX_COLS)
	) u_up_ram (
		.clk(clk),
		.wr_en(done_s1),
		.wr_addr(col_s1),
		.wr_data(mid_rd),
		.rd_en(accept),
		.rd_addr(col_idx),
		.rd_data(up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix_sat;
			col_s1 <= col_idx;
			tag_s1 <= tag;
		end
	end

	btm_classify u_classify (
		.clk(clk),
		.shift_en(done_s1),
		.up_in(up_rd),
		.mid_in(mid_rd),
		.pix_in(pix_s1),
		.blank(tag_s1.blank),
		.threshold(threshold),
		.mark(mark_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (done_s1 && tag_s1.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && tag_s1.emit) begin
			row_q        <= tag_s1.row;
			col_q        <= tag_s1.col;
			mark_q       <= mark_c;
			frame_done_q <= tag_s1.done;
		end
	end

	assign result_valid = result_valid_q;
	assign center_row   = row_q;
	assign center_col   = col_q;
	assign mark         = mark_q;
	assign frame_done   = frame_done_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> (v_s1 && tag_s1.emit && result_valid_q && !result_ready))
		else $error("input stalled without a blocked result");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(col_s1) && $stable(pix_s1) && $stable(tag_s1)))
		else $error("stage 1 lost its beat while stalled");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s1 && tag_s1.emit) |=> result_valid_q)
		else $error("finished result not presented");

endmodule

### sv/btm_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module btm_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/btm_ctrl.sv
// Configuration registers and raster position counters.
module btm_ctrl #(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [btm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [btm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             advance,
	output logic [$clog2(MAX_COLS)-1:0]      col_idx,
	output btm_pkg::tag_t                    tag,
	output logic [7:0]                       threshold
);

	localparam int CW   = $clog2(MAX_COLS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CCMP = (CW + 1 > 6) ? CW + 1 : 6;
	localparam int RCMP = (RW + 1 > 6) ? RW + 1 : 6;

	logic [5:0]    cols_q;
	logic [5:0]    rows_q;
	logic [7:0]    thresh_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic [CCMP-1:0] cols_ext;
	logic [RCMP-1:0] rows_ext;
	logic [RW-1:0] row_m1;
	logic [CW-1:0] col_m1;
	logic          cfg_hit;

	// Sizes are clamped to 1..MAX so the counters always stay in range.
	always_comb begin
		cols_ext = CCMP'(cols_q);
		rows_ext = RCMP'(rows_q);
		if (cols_q == '0) begin
			col_last = '0;
		end else if (cols_ext > CCMP'(MAX_COLS)) begin
			col_last = CW'(MAX_COLS - 1);
		end else begin
			col_last = CW'(cols_ext - 1'b1);
		end
		if (rows_q == '0) begin
			row_last = '0;
		end else if (rows_ext > RCMP'(MAX_ROWS)) begin
			row_last = RW'(MAX_ROWS - 1);
		end else begin
			row_last = RW'(rows_ext - 1'b1);
		end
	end

	always_comb begin
		case (cfg_index)
			btm_pkg::CFG_FRAME_COLUMNS:      cfg_hit = cfg_valid;
			btm_pkg::CFG_FRAME_ROWS:         cfg_hit = cfg_valid;
			btm_pkg::CFG_STAR_SUM_THRESHOLD: cfg_hit = cfg_valid;
			default:                         cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= btm_pkg::FRAME_COLUMNS_RST;
			rows_q   <= btm_pkg::FRAME_ROWS_RST;
			thresh_q <= btm_pkg::STAR_SUM_THRESHOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				btm_pkg::CFG_FRAME_COLUMNS:      cols_q   <= cfg_data[5:0];
				btm_pkg::CFG_FRAME_ROWS:         rows_q   <= cfg_data[5:0];
				btm_pkg::CFG_STAR_SUM_THRESHOLD: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A write to any of the three configuration registers restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_q == col_last) begin
				col_q <= '0;
				if (row_q == row_last) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	assign row_m1 = row_q - 1'b1;
	assign col_m1 = col_q - 1'b1;

	always_comb begin
		tag.emit  = (row_q != '0) && (col_q != '0);
		tag.blank = (row_q == RW'(1)) || (col_q == CW'(1));
		tag.done  = (row_q == row_last) && (col_q == col_last);
		tag.row   = btm_pkg::POS_W'(row_m1);
		tag.col   = btm_pkg::POS_W'(col_m1);
	end

	assign col_idx   = col_q;
	assign threshold = thresh_q;

	a_counters_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= col_last) && (row_q <= row_last))
		else $error("position counter beyond the clamped frame");

endmodule

### sv/btm_classify.sv
// 3x3 window registers, neighborhood sum and star/dot decision.
module btm_classify (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic [btm_pkg::PIX_W-1:0]     up_in,
	input  logic [btm_pkg::PIX_W-1:0]     mid_in,
	input  logic [btm_pkg::PIX_W-1:0]     pix_in,
	input  logic                          blank,
	input  logic [7:0]                    threshold,
	output btm_pkg::mark_t                mark
);

	// Two older window columns; the newest column comes straight from the inputs.
	logic [btm_pkg::PIX_W-1:0] col0_q [3];
	logic [btm_pkg::PIX_W-1:0] col1_q [3];
	logic [btm_pkg::SUM_W-1:0] sum;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col0_q[0] <= col1_q[0];
			col0_q[1] <= col1_q[1];
			col0_q[2] <= col1_q[2];
			col1_q[0] <= up_in;
			col1_q[1] <= mid_in;
			col1_q[2] <= pix_in;
		end
	end

	always_comb begin
		sum = btm_pkg::SUM_W'(col0_q[0]) + btm_pkg::SUM_W'(col0_q[1])
			+ btm_pkg::SUM_W'(col0_q[2]) + btm_pkg::SUM_W'(col1_q[0])
			+ btm_pkg::SUM_W'(col1_q[1]) + btm_pkg::SUM_W'(col1_q[2])
			+ btm_pkg::SUM_W'(up_in) + btm_pkg::SUM_W'(mid_in)
			+ btm_pkg::SUM_W'(pix_in);
		if (blank) begin
			mark = btm_pkg::MARK_BLANK;
		end else if (sum > btm_pkg::SUM_W'(threshold)) begin
			mark = btm_pkg::MARK_STAR;
		end else begin
			mark = btm_pkg::MARK_DOT;
		end
	end

endmodule

### test/tb_box3x3_threshold_marker.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 box threshold marker with its own pixel-level predictor.
module tb_box3x3_threshold_marker;

	localparam int MAX_COLS      = 32;
	localparam int MAX_ROWS      = 32;
	localparam int CLK_HALF      = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int TARGET_PIXELS = 700;
	localparam int QUIET_AFTER   = 600;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_CAP     = 160;

	// Index 3 decodes to no register; a write there must not restart the frame.
	localparam logic [btm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic [btm_pkg::POS_W-1:0] row;
		logic [btm_pkg::POS_W-1:0] col;
		btm_pkg::mark_t            mark;
		logic                      done;
	} marked_pixel_t;

	class marker_checker;
		logic [5:0]                frame_columns;
		logic [5:0]                frame_rows;
		logic [7:0]                star_threshold;
		logic [btm_pkg::PIX_W-1:0] line_upper [MAX_COLS];
		logic [btm_pkg::PIX_W-1:0] line_middle [MAX_COLS];
		logic [btm_pkg::PIX_W-1:0] window [9];
		int unsigned               row_pos;
		int unsigned               col_pos;
		marked_pixel_t             pending_marks [$];
		int unsigned               errors, results, stars, dots, blanks, frames;

		function new();
			frame_columns  = btm_pkg::FRAME_COLUMNS_RST;
			frame_rows     = btm_pkg::FRAME_ROWS_RST;
			star_threshold = btm_pkg::STAR_SUM_THRESHOLD_RST;
			foreach (line_upper[i]) begin
				line_upper[i]  = '0;
				line_middle[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			row_pos = 0;
			col_pos = 0;
			errors  = 0;
			results = 0;
			stars   = 0;
			dots    = 0;
			blanks  = 0;
			frames  = 0;
		endfunction

		function int unsigned clamp_size(logic [5:0] v, int unsigned lim);
			if (v == 0)
				return 1;
			if (v > lim)
				return lim;
			return v;
		endfunction

		function int unsigned frame_pixels();
			return clamp_size(frame_columns, MAX_COLS) * clamp_size(frame_rows, MAX_ROWS);
		endfunction

		function int pending();
			return pending_marks.size();
		endfunction

		function void write_reg(logic [btm_pkg::CFG_IDX_W-1:0] idx,
				logic [btm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				btm_pkg::CFG_FRAME_COLUMNS:      frame_columns = data[5:0];
				btm_pkg::CFG_FRAME_ROWS:         frame_rows = data[5:0];
				btm_pkg::CFG_STAR_SUM_THRESHOLD: star_threshold = data;
				default:                         return;
			endcase
			row_pos = 0;
			col_pos = 0;
		endfunction

		function void note_pixel(logic [btm_pkg::PIX_W-1:0] raw);
			int unsigned   cols, rows, r, c, sum;
			logic [btm_pkg::PIX_W-1:0] p;
			marked_pixel_t m;
			cols = clamp_size(frame_columns, MAX_COLS);
			rows = clamp_size(frame_rows, MAX_ROWS);
			p = (raw > btm_pkg::PIXEL_MAX) ? btm_pkg::PIXEL_MAX : raw;
			if (col_pos >= cols)
				col_pos = 0;
			if (row_pos >= rows)
				row_pos = 0;
			r = row_pos;
			c = col_pos;

			for (int i = 0; i < 3; i++) begin
				window[i*3]   = window[i*3+1];
				window[i*3+1] = window[i*3+2];
			end
			window[2] = line_upper[c];
			window[5] = line_middle[c];
			window[8] = p;
			line_upper[c]  = line_middle[c];
			line_middle[c] = p;

			// The pixel up and to the left is now fully surrounded by the window.
			if (r >= 1 && c >= 1) begin
				if (r == 1 || c == 1) begin
					m.mark = btm_pkg::MARK_BLANK;
				end else begin
					sum = 0;
					foreach (window[i]) sum += window[i];
					m.mark = (sum > star_threshold) ? btm_pkg::MARK_STAR : btm_pkg::MARK_DOT;
				end
				m.done = (r == rows - 1 && c == cols - 1);
				m.row  = btm_pkg::POS_W'(r - 1);
				m.col  = btm_pkg::POS_W'(c - 1);
				pending_marks.push_back(m);
			end

			col_pos = c + 1;
			if (col_pos >= cols) begin
				col_pos = 0;
				row_pos = r + 1;
				if (row_pos >= rows)
					row_pos = 0;
			end
		endfunction

		function void check_result(logic [btm_pkg::POS_W-1:0] row,
				logic [btm_pkg::POS_W-1:0] col, logic [1:0] mk, logic done);
			marked_pixel_t e;
			if (pending_marks.size() == 0) begin
				$error("result beat with no classification pending: row %0d col %0d", row, col);
				errors++;
				return;
			end
			e = pending_marks.pop_front();
			results++;
			case (e.mark)
				btm_pkg::MARK_STAR: stars++;
				btm_pkg::MARK_DOT:  dots++;
				default:            blanks++;
			endcase
			if (e.done)
				frames++;
			if (row !== e.row) begin
				$error("center_row: expected %0d, got %0d", e.row, row);
				errors++;
			end
			if (col !== e.col) begin
				$error("center_col: expected %0d, got %0d", e.col, col);
				errors++;
			end
			if (mk !== e.mark) begin
				$error("mark: expected %0d, got %0d", e.mark, mk);
				errors++;
			end
			if (done !== e.done) begin
				$error("frame_done: expected %0d, got %0d", e.done, done);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n       = 1'b0;
	logic                           cfg_valid    = 1'b0;
	logic                           cfg_ready;
	logic [btm_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [btm_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
	logic                           pixel_valid  = 1'b0;
	logic                           pixel_ready;
	logic [btm_pkg::PIX_W-1:0]      pixel_value  = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	logic [btm_pkg::POS_W-1:0]      center_row;
	logic [btm_pkg::POS_W-1:0]      center_col;
	logic [1:0]                     mark;
	logic                           frame_done;

	marker_checker sb;
	int unsigned   pixels_sent  = 0;
	int unsigned   cfg_writes   = 0;
	int unsigned   cycles       = 0;
	int unsigned   tx_idle_pct  = 0;
	int unsigned   rx_stall_pct = 0;
	bit            quiet        = 1'b0;
	logic [btm_pkg::PIX_W-1:0] directed_pixels [24];

	box3x3_threshold_marker #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel_value(pixel_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.center_row(center_row),
		.center_col(center_col),
		.mark(mark),
		.frame_done(frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(center_row, center_col, mark, frame_done);
	end

	// The receiver holds ready high for a while, then may stall for a short burst.
	initial begin : result_sink
		forever begin
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	function automatic logic [btm_pkg::CFG_DATA_W-1:0] pick_size();
		int unsigned sel;
		logic [5:0] size;
		sel = $urandom_range(0, 15);
		case (sel)
			0:       size = 6'd0;
			1:       size = 6'd1;
			2:       size = 6'd32;
			3:       size = 6'($urandom_range(33, 63));
			default: size = 6'($urandom_range(2, 8));
		endcase
		// The upper data bits are ignored for the size registers.
		return {2'($urandom_range(0, 3)), size};
	endfunction

	task automatic send_pixel(input logic [btm_pkg::PIX_W-1:0] v);
		int unsigned gap;
		pixel_valid <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (!pixel_ready);
		sb.note_pixel(v);
		pixels_sent++;
		quiet = (pixels_sent >= QUIET_AFTER);
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Leaves cfg_valid high; the caller lowers it after its last write.
	task automatic write_reg(input logic [btm_pkg::CFG_IDX_W-1:0] idx,
			input logic [btm_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Beats that produce no result may still be in the pipeline once the queue is empty.
	task automatic settle();
		pixel_valid <= 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned n, fp;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 3x4 frame of sixes puts the first sum exactly on the threshold and the
		// second one just above it; the next frame has the extremes and saturation.
		directed_pixels = '{5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
				5'd6, 5'd6, 5'd7, 5'd0, 5'd0, 5'd0, 5'd31, 5'd21, 5'd20,
				5'd20, 5'd20, 5'd20, 5'd0, 5'd0, 5'd0};
		write_reg(btm_pkg::CFG_FRAME_COLUMNS, 8'hC3);
		write_reg(btm_pkg::CFG_FRAME_ROWS, 8'd4);
		write_reg(btm_pkg::CFG_STAR_SUM_THRESHOLD, 8'd54);
		cfg_valid <= 1'b0;
		foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);

		while (pixels_sent < TARGET_PIXELS) begin
			settle();
			tx_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			if ($urandom_range(0, 2) != 0)
				write_reg(btm_pkg::CFG_FRAME_COLUMNS, pick_size());
			if ($urandom_range(0, 2) != 0)
				write_reg(btm_pkg::CFG_FRAME_ROWS, pick_size());
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0:       write_reg(btm_pkg::CFG_STAR_SUM_THRESHOLD, 8'd0);
					1:       write_reg(btm_pkg::CFG_STAR_SUM_THRESHOLD, 8'd180);
					2:       write_reg(btm_pkg::CFG_STAR_SUM_THRESHOLD, 8'd255);
					default: write_reg(btm_pkg::CFG_STAR_SUM_THRESHOLD,
							8'($urandom_range(0, 180)));
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
			cfg_valid <= 1'b0;

			// Mostly whole frames, sometimes cut short by the next register write.
			fp = sb.frame_pixels();
			n = fp * $urandom_range(1, 2) + $urandom_range(0, fp / 2);
			if (n > PHASE_CAP)
				n = PHASE_CAP;
			if (n > TARGET_PIXELS - pixels_sent)
				n = TARGET_PIXELS - pixels_sent;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_pixel(5'($urandom_range(21, 31)));
				else
					send_pixel(5'($urandom_range(0, 20)));
				if ($urandom_range(0, 149) == 0) begin
					pixel_valid <= 1'b0;
					drain();
				end
			end
		end

		settle();
		$display("%0d pixels in, %0d register writes, %0d classified (%0d star, %0d dot, %0d border)",
				pixels_sent, cfg_writes, sb.results, sb.stars, sb.dots, sb.blanks);
		$display("%0d frames closed with frame_done, %0d mismatches", sb.frames, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
